@@ rtl/core/sensor_calibrate_and_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Sensor calibrate and filter: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_CALIBRATE_AND_FILTER_MACROS_SVH
`define SENSOR_CALIBRATE_AND_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SCF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("scf port check failed");

// next-cycle implication, disabled while reset is low
`define SCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scf port check failed");

`endif

@@ rtl/core/scf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg
// Types, constants and codes shared by the sensor conditioning block.
// ----------------------------------------------------------------------------
package scf_pkg;

  // defaults for top level parameters
  localparam int DEF_CHANNELS   = 64;
  localparam int DEF_EXP_WEIGHT = 100;

  // datapath widths
  localparam int DATA_W = 16;
  localparam int OPND_W = 17;
  localparam int PROD_W = 34;
  localparam int HOLD_W = 7;
  localparam int SLOT_W = 4;
  localparam int NUM_SET = 10;

  // serial unit step counts (two bits per step)
  localparam int MUL_STEPS = (OPND_W + 1) / 2;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int STEP_W    = 5;

  // filter constants
  localparam int SCALE      = 1000;
  localparam int HOLD_LIMIT = 30;
  localparam int HOLD_MAX   = 120;

  // item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_SET    = 1'b1;

  // module status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  // setting word slots
  localparam logic [3:0] IDX_U0     = 4'd0;
  localparam logic [3:0] IDX_U1     = 4'd1;
  localparam logic [3:0] IDX_V0     = 4'd2;
  localparam logic [3:0] IDX_V1     = 4'd3;
  localparam logic [3:0] IDX_RAWMIN = 4'd4;
  localparam logic [3:0] IDX_RAWMAX = 4'd5;
  localparam logic [3:0] IDX_VMIN   = 4'd6;
  localparam logic [3:0] IDX_VMAX   = 4'd7;
  localparam logic [3:0] IDX_FLAGS  = 4'd8;
  localparam logic [3:0] IDX_TOL    = 4'd9;

  // flag bit positions
  localparam int FLG_CLAMP_LO = 0;
  localparam int FLG_CLAMP_HI = 1;
  localparam int FLG_AVG_LO   = 2;
  localparam int FLG_OUTDOOR  = 4;

  // averaging modes
  localparam logic [1:0] AVG_NONE  = 2'd0;
  localparam logic [1:0] AVG_TWO   = 2'd1;
  localparam logic [1:0] AVG_THREE = 2'd2;
  localparam logic [1:0] AVG_EXP   = 2'd3;

  // per-channel history row
  typedef struct packed {
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] sec;
    logic signed [DATA_W-1:0] stored;
    logic [HOLD_W-1:0]        hold;
  } hist_t;

  // requests to the serial units
  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dvd;
    logic signed [OPND_W-1:0] dvs;
  } div_req_t;

endpackage

@@ rtl/core/scf_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_mul
// Serial signed multiplier, 17 x 17 bits, two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module scf_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scf_pkg::mul_req_t               req,
  output logic signed [scf_pkg::PROD_W-1:0] prod,
  output logic                            done
);

  logic [scf_pkg::PROD_W-1:0]   mc_r;
  logic [scf_pkg::OPND_W:0]     mp_r;
  logic [scf_pkg::PROD_W-1:0]   acc_r;
  logic [scf_pkg::STEP_W-1:0]   cnt_r;
  logic                         busy_r;
  logic                         fin_r;
  logic                         neg_r;
  logic                         done_r;
  logic signed [scf_pkg::PROD_W-1:0] prod_r;
  logic [scf_pkg::OPND_W-1:0]   mag_a;
  logic [scf_pkg::OPND_W-1:0]   mag_b;
  logic [scf_pkg::PROD_W-1:0]   acc_nxt;

  // operand magnitudes
  assign mag_a = req.a[scf_pkg::OPND_W-1] ? -req.a : req.a;
  assign mag_b = req.b[scf_pkg::OPND_W-1] ? -req.b : req.b;

  // one radix-4 digit per cycle
  assign acc_nxt = acc_r + (mp_r[0] ? mc_r : '0)
                 + (mp_r[1] ? {mc_r[scf_pkg::PROD_W-2:0], 1'b0} : '0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= scf_pkg::STEP_W'(scf_pkg::MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == scf_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      mc_r  <= scf_pkg::PROD_W'(mag_a);
      mp_r  <= {1'b0, mag_b};
      acc_r <= '0;
      neg_r <= req.a[scf_pkg::OPND_W-1] ^ req.b[scf_pkg::OPND_W-1];
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mc_r  <= {mc_r[scf_pkg::PROD_W-3:0], 2'b00};
      mp_r  <= {2'b00, mp_r[scf_pkg::OPND_W:2]};
    end
    if (fin_r) begin
      prod_r <= neg_r ? -$signed(acc_r) : $signed(acc_r);
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

@@ rtl/core/scf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_div
// Serial signed divider, 34 / 17 bits, two quotient bits per cycle.
// Quotient truncates toward zero and is returned wrapped to 16 bits.
// ----------------------------------------------------------------------------
module scf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scf_pkg::div_req_t                 req,
  output logic signed [scf_pkg::DATA_W-1:0] quo,
  output logic                              done
);

  logic [scf_pkg::PROD_W-1:0] nm_r;
  logic [scf_pkg::OPND_W-1:0] dm_r;
  logic [scf_pkg::OPND_W-1:0] rem_r;
  logic [scf_pkg::DATA_W-1:0] q_r;
  logic [scf_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       fin_r;
  logic                       neg_r;
  logic                       done_r;
  logic signed [scf_pkg::DATA_W-1:0] quo_r;
  logic [scf_pkg::OPND_W:0]   r1;
  logic [scf_pkg::OPND_W:0]   r1s;
  logic [scf_pkg::OPND_W:0]   r2;
  logic [scf_pkg::OPND_W:0]   r2s;
  logic                       ge1;
  logic                       ge2;

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem_r, nm_r[scf_pkg::PROD_W-1]};
    ge1 = r1 >= {1'b0, dm_r};
    r1s = ge1 ? r1 - {1'b0, dm_r} : r1;
    r2  = {r1s[scf_pkg::OPND_W-1:0], nm_r[scf_pkg::PROD_W-2]};
    ge2 = r2 >= {1'b0, dm_r};
    r2s = ge2 ? r2 - {1'b0, dm_r} : r2;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= scf_pkg::STEP_W'(scf_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == scf_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      nm_r  <= req.dvd[scf_pkg::PROD_W-1] ? -req.dvd : req.dvd;
      dm_r  <= req.dvs[scf_pkg::OPND_W-1] ? -req.dvs : req.dvs;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= req.dvd[scf_pkg::PROD_W-1] ^ req.dvs[scf_pkg::OPND_W-1];
    end else if (busy_r) begin
      rem_r <= r2s[scf_pkg::OPND_W-1:0];
      q_r   <= {q_r[scf_pkg::DATA_W-3:0], ge1, ge2};
      nm_r  <= {nm_r[scf_pkg::PROD_W-3:0], 2'b00};
    end
    if (fin_r) begin
      quo_r <= neg_r ? -$signed(q_r) : $signed(q_r);
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

@@ rtl/core/sensor_calibrate_and_filter.sv @@
`timescale 1ns / 1ps
// A setting word or an ignored word goes straight to the result. A sample fetches its
// settings, then multiplies and divides; an absent module skips both, equal raw points the
// divide. Two- or three-point averaging may add a divide, exponential two products and a divide.
// One word in flight, the next taken from the cycle in which out_valid rises; setting fetch,
// serial multiplier and serial divider set how long a word takes.
// Reset (synchronous, rst_n low) starts a clearing pass over both stores, input stalled.
// ----------------------------------------------------------------------------
// sensor_calibrate_and_filter
// Per-channel two-point calibration, range checks, averaging and jump filter.
// ----------------------------------------------------------------------------
module sensor_calibrate_and_filter #(
  parameter int CHANNELS   = scf_pkg::DEF_CHANNELS,
  parameter int EXP_WEIGHT = scf_pkg::DEF_EXP_WEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [5:0]         in_channel,
  input  logic [3:0]         in_setting_index,
  input  logic signed [15:0] in_setting_value,
  input  logic signed [15:0] in_raw,
  input  logic [1:0]         in_module_status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_value,
  output logic               out_raw_range_error,
  output logic               out_value_range_error,
  output logic               out_no_module,
  output logic               out_held
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SET_DEPTH = CHANNELS * (2 ** scf_pkg::SLOT_W);
  localparam int SET_AW    = CH_W + scf_pkg::SLOT_W;
  localparam int DW        = scf_pkg::DATA_W;
  localparam int OW        = scf_pkg::OPND_W;
  localparam int PW        = scf_pkg::PROD_W;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_FETCH = 13'b0000000000100,
    S_CHECK = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_DIV1  = 13'b0000000100000,
    S_LIMIT = 13'b0000001000000,
    S_AVG   = 13'b0000010000000,
    S_EMUL1 = 13'b0000100000000,
    S_EMUL2 = 13'b0001000000000,
    S_DIV2  = 13'b0010000000000,
    S_JUMP  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SET_AW-1:0]     clr_cnt_r;
  logic [3:0]            fidx_r;
  logic [CH_W-1:0]       ch_idx_r;
  logic [1:0]            status_r;
  logic signed [DW-1:0]  raw_r;
  logic                  smp_r;
  logic                  exp_r;
  logic signed [DW-1:0]  set_r [scf_pkg::NUM_SET];
  logic [DW-1:0]         set_rd_r;
  scf_pkg::hist_t        hist_rd_r;
  logic signed [DW-1:0]  hp_r, hs_r, hsv_r;
  logic [scf_pkg::HOLD_W-1:0] hc_r;
  logic signed [DW-1:0]  v_r;
  logic signed [PW-1:0]  acc_r;
  logic                  rerr_r, verr_r, nomod_r, held_r;
  logic                  out_valid_r;
  logic signed [DW-1:0]  out_value_r;
  logic                  out_rerr_r, out_verr_r, out_nomod_r, out_held_r;

  // memories
  logic [DW-1:0]         set_mem [SET_DEPTH];
  scf_pkg::hist_t        hist_mem [CHANNELS];

  logic                  in_acc;
  logic                  ch_ok;
  logic                  set_we;
  logic [SET_AW-1:0]     set_wa;
  logic [DW-1:0]         set_wd;
  logic                  hist_we;
  logic [CH_W-1:0]       hist_wa;
  scf_pkg::hist_t        hist_wd;
  logic                  out_free;
  logic                  clr_last;

  scf_pkg::mul_req_t     mul_req;
  scf_pkg::div_req_t     div_req;
  logic signed [PW-1:0]  mul_prod;
  logic                  mul_done;
  logic signed [DW-1:0]  div_quo;
  logic                  div_done;

  // decoded settings and working values
  logic [DW-1:0]         flags;
  logic                  outdoor;
  logic [1:0]            avg;
  logic signed [DW-1:0]  raw_eff;
  logic                  rerr_now;
  logic signed [OW-1:0]  den;
  logic signed [DW-1:0]  v_lim;
  logic                  verr_lim;
  logic signed [DW-1:0]  avg_x;
  logic [1:0]            avg_n;
  logic signed [DW+1:0]  avg_sum;
  logic signed [DW-1:0]  exp_p;
  logic signed [DW+1:0]  jmp_v, jmp_hi, jmp_lo;
  logic                  jmp_pass;

  assign in_acc   = in_valid && !in_stall;
  assign ch_ok    = int'(in_channel) < CHANNELS;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_cnt_r == SET_AW'(SET_DEPTH - 1));

  // setting decode
  always_comb begin
    flags    = set_r[scf_pkg::IDX_FLAGS];
    outdoor  = flags[scf_pkg::FLG_OUTDOOR];
    avg      = flags[scf_pkg::FLG_AVG_LO +: 2];
    raw_eff  = (status_r == scf_pkg::STATUS_OK) ? raw_r : '0;
    rerr_now = (raw_eff < set_r[scf_pkg::IDX_RAWMIN]) ||
               (raw_eff > set_r[scf_pkg::IDX_RAWMAX]);
    den      = OW'(set_r[scf_pkg::IDX_U1]) - OW'(set_r[scf_pkg::IDX_U0]);
  end

  // value limits: low test first, then high on the updated value
  always_comb begin
    v_lim    = v_r;
    verr_lim = 1'b0;
    if (v_lim < set_r[scf_pkg::IDX_VMIN]) begin
      if (flags[scf_pkg::FLG_CLAMP_LO]) begin
        v_lim = set_r[scf_pkg::IDX_VMIN];
      end else begin
        v_lim    = '0;
        verr_lim = 1'b1;
      end
    end
    if (v_lim > set_r[scf_pkg::IDX_VMAX]) begin
      if (flags[scf_pkg::FLG_CLAMP_HI]) begin
        v_lim = set_r[scf_pkg::IDX_VMAX];
      end else begin
        v_lim    = '0;
        verr_lim = 1'b1;
      end
    end
  end

  // averaging terms
  always_comb begin
    avg_x   = (avg == scf_pkg::AVG_TWO) ? '0 : hs_r;
    avg_n   = 2'(v_r != '0) + 2'(avg_x != '0) + 2'(hp_r != '0);
    avg_sum = (DW+2)'(v_r) + (DW+2)'(avg_x) + (DW+2)'(hp_r);
    exp_p   = (hp_r == '0) ? v_r : hp_r;
  end

  // jump window around the stored value
  always_comb begin
    jmp_v    = (DW+2)'(v_r);
    jmp_hi   = (DW+2)'(hsv_r) + $signed({2'b00, set_r[scf_pkg::IDX_TOL]});
    jmp_lo   = (DW+2)'(hsv_r) - $signed({2'b00, set_r[scf_pkg::IDX_TOL]});
    jmp_pass = ((jmp_v < jmp_hi) && (jmp_v > jmp_lo)) ||
               (hc_r > scf_pkg::HOLD_W'(scf_pkg::HOLD_LIMIT)) || (hsv_r == '0);
  end

  // requests to the serial units
  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state_r)
      S_CHECK: begin
        mul_req.start = (status_r != scf_pkg::STATUS_ABSENT);
        mul_req.a = OW'(set_r[scf_pkg::IDX_V1]) - OW'(set_r[scf_pkg::IDX_V0]);
        mul_req.b = OW'(raw_eff) - OW'(set_r[scf_pkg::IDX_U0]);
      end
      S_MUL: begin
        div_req.start = mul_done && (den != '0);
        div_req.dvd   = mul_prod;
        div_req.dvs   = den;
      end
      S_AVG: begin
        mul_req.start = (avg == scf_pkg::AVG_EXP);
        mul_req.a     = OW'(exp_p);
        mul_req.b     = OW'(scf_pkg::SCALE - EXP_WEIGHT);
        div_req.start = ((avg == scf_pkg::AVG_TWO) || (avg == scf_pkg::AVG_THREE)) &&
                        !outdoor && (avg_n != 2'd0);
        div_req.dvd   = PW'(avg_sum);
        div_req.dvs   = OW'(avg_n);
      end
      S_EMUL1: begin
        mul_req.start = mul_done;
        mul_req.a     = OW'(v_r);
        mul_req.b     = OW'(EXP_WEIGHT);
      end
      S_EMUL2: begin
        div_req.start = mul_done;
        div_req.dvd   = acc_r + mul_prod;
        div_req.dvs   = OW'(scf_pkg::SCALE);
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (ch_ok && in_mode == scf_pkg::MODE_SAMPLE) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: if (fidx_r == 4'(scf_pkg::NUM_SET)) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (status_r == scf_pkg::STATUS_ABSENT) ? S_DONE : S_MUL;
      S_MUL: begin
        if (mul_done) state_nxt = (den != '0) ? S_DIV1 : S_LIMIT;
      end
      S_DIV1: if (div_done) state_nxt = S_LIMIT;
      S_LIMIT: state_nxt = S_AVG;
      S_AVG: begin
        if (mul_req.start) begin
          state_nxt = S_EMUL1;
        end else if (div_req.start) begin
          state_nxt = S_DIV2;
        end else begin
          state_nxt = S_JUMP;
        end
      end
      S_EMUL1: if (mul_done) state_nxt = S_EMUL2;
      S_EMUL2: if (mul_done) state_nxt = S_DIV2;
      S_DIV2: if (div_done) state_nxt = S_JUMP;
      S_JUMP: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fidx_r      <= '0;
      ch_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_FETCH) begin
        fidx_r <= fidx_r + 1'b1;
      end else begin
        fidx_r <= '0;
      end
      if (in_acc && ch_ok) ch_idx_r <= CH_W'(in_channel);
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        status_r <= in_module_status;
        raw_r    <= in_raw;
        smp_r    <= ch_ok && (in_mode == scf_pkg::MODE_SAMPLE);
        exp_r    <= 1'b0;
        v_r      <= '0;
        rerr_r   <= 1'b0;
        verr_r   <= 1'b0;
        nomod_r  <= 1'b0;
        held_r   <= 1'b0;
      end
      S_FETCH: begin
        if (fidx_r != 4'd0) set_r[fidx_r - 4'd1] <= set_rd_r;
      end
      S_CHECK: begin
        hp_r <= hist_rd_r.prev;
        hs_r <= hist_rd_r.sec;
        hc_r <= hist_rd_r.hold;
        // missing module clears the stored value of an indoor channel
        if (status_r == scf_pkg::STATUS_ABSENT && !outdoor) begin
          hsv_r <= '0;
        end else begin
          hsv_r <= hist_rd_r.stored;
        end
        if (status_r == scf_pkg::STATUS_ABSENT) begin
          nomod_r <= 1'b1;
        end else begin
          rerr_r <= rerr_now;
        end
      end
      S_MUL: begin
        if (mul_done && den == '0) v_r <= set_r[scf_pkg::IDX_V0];
      end
      S_DIV1: begin
        if (div_done) v_r <= div_quo + set_r[scf_pkg::IDX_V0];
      end
      S_LIMIT: begin
        v_r    <= v_lim;
        verr_r <= verr_lim;
      end
      S_AVG: begin
        if ((avg == scf_pkg::AVG_TWO || avg == scf_pkg::AVG_THREE) && !outdoor) begin
          hs_r <= hp_r;
          hp_r <= v_r;
        end else if (avg == scf_pkg::AVG_TWO) begin
          hs_r <= '0;
        end
        exp_r <= (avg == scf_pkg::AVG_EXP);
      end
      S_EMUL1: begin
        if (mul_done) acc_r <= mul_prod;
      end
      S_DIV2: begin
        if (div_done) begin
          v_r <= div_quo;
          if (exp_r) hp_r <= div_quo;
        end
      end
      S_JUMP: begin
        if (!outdoor && !jmp_pass) begin
          v_r    <= hsv_r;
          held_r <= 1'b1;
          if (hc_r < scf_pkg::HOLD_W'(scf_pkg::HOLD_MAX)) hc_r <= hc_r + 1'b1;
        end else begin
          hsv_r <= v_r;
          if (!outdoor) hc_r <= '0;
        end
      end
      default: begin
      end
    endcase
    // result word register
    if (state_r == S_DONE && out_free) begin
      out_value_r <= v_r;
      out_rerr_r  <= rerr_r;
      out_verr_r  <= verr_r;
      out_nomod_r <= nomod_r;
      out_held_r  <= held_r;
    end
  end

  // setting store: clearing pass, setting writes, serial fetch
  always_comb begin
    set_we = (state_r == S_CLEAR) ||
             (in_acc && ch_ok && in_mode == scf_pkg::MODE_SET &&
              in_setting_index <= scf_pkg::IDX_TOL);
    set_wa = (state_r == S_CLEAR) ? clr_cnt_r : {CH_W'(in_channel), in_setting_index};
    set_wd = (state_r == S_CLEAR) ? '0 : in_setting_value;
  end

  always_ff @(posedge clk) begin
    if (set_we) set_mem[set_wa] <= set_wd;
    set_rd_r <= set_mem[{ch_idx_r, fidx_r}];
  end

  // channel history store
  always_comb begin
    hist_we = (state_r == S_CLEAR) || (state_r == S_DONE && out_free && smp_r);
    hist_wa = (state_r == S_CLEAR) ? clr_cnt_r[SET_AW-1:scf_pkg::SLOT_W] : ch_idx_r;
    hist_wd = (state_r == S_CLEAR) ? '0 : {hp_r, hs_r, hsv_r, hc_r};
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[ch_idx_r];
  end

  scf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  scf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign out_valid             = out_valid_r;
  assign out_value             = out_value_r;
  assign out_raw_range_error   = out_rerr_r;
  assign out_value_range_error = out_verr_r;
  assign out_no_module         = out_nomod_r;
  assign out_held              = out_held_r;

endmodule

@@ rtl/core/scf_port_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_port_checker
// Port-level checks on the sensor conditioning block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_calibrate_and_filter_macros.svh"

module scf_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_value,
  input logic               out_raw_range_error,
  input logic               out_value_range_error,
  input logic               out_no_module,
  input logic               out_held
);

  // a waiting result word holds
  `SCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value))

  // one word in flight: a taken word closes the input
  `SCF_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

  // missing module gives a bare result
  `SCF_ASSERT_NOW(a_no_module, clk, rst_n, out_valid && out_no_module, out_value == 16'sd0 && !out_held && !out_raw_range_error && !out_value_range_error)

endmodule

bind sensor_calibrate_and_filter scf_port_checker u_port_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_value             (out_value),
  .out_raw_range_error   (out_raw_range_error),
  .out_value_range_error (out_value_range_error),
  .out_no_module         (out_no_module),
  .out_held              (out_held)
);

@@ test/sensor_calibrate_and_filter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_calibrate_and_filter_checker
// Watches the sample and result channels of the sensor conditioning block,
// keeps its own copy of the per-channel settings and history, predicts every
// result word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sensor_calibrate_and_filter_checker #(
  parameter int CHANNELS   = scf_pkg::DEF_CHANNELS,
  parameter int EXP_WEIGHT = scf_pkg::DEF_EXP_WEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode,
  input  logic [5:0]         in_channel,
  input  logic [3:0]         in_setting_index,
  input  logic signed [15:0] in_setting_value,
  input  logic signed [15:0] in_raw,
  input  logic [1:0]         in_module_status,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_value,
  input  logic               out_raw_range_error,
  input  logic               out_value_range_error,
  input  logic               out_no_module,
  input  logic               out_held,
  output int                 fail_count,
  output int                 pending_results,
  output int                 samples_seen,
  output int                 held_seen
);

  typedef struct packed {
    logic signed [15:0] value;
    logic               rerr;
    logic               verr;
    logic               nomod;
    logic               held;
  } cond_word_t;

  // model state
  logic [15:0]        settings [CHANNELS][16];
  logic signed [15:0] prev_smp [CHANNELS];
  logic signed [15:0] sec_smp  [CHANNELS];
  logic signed [15:0] kept_val [CHANNELS];
  int                 hold_cnt [CHANNELS];
  cond_word_t         expected_words [$];

  function automatic logic signed [15:0] setw(int ch, logic [3:0] idx);
    return settings[ch][idx];
  endfunction

  // conditioned value for one item, updating channel history
  function automatic cond_word_t condition_sample(logic mode, int ch, logic [3:0] sidx,
                                                  logic [15:0] sval, logic signed [15:0] rin,
                                                  logic [1:0] st);
    cond_word_t r;
    logic [15:0] flags;
    logic outdoor;
    longint num, den, q64, p, v;
    logic signed [15:0] q, rawv;
    int x, y, n, sv, tol;
    logic [1:0] avg;
    r = '0;
    if (ch >= CHANNELS) return r;
    if (mode == scf_pkg::MODE_SET) begin
      if (sidx < scf_pkg::NUM_SET) settings[ch][sidx] = sval;
      return r;
    end
    flags = settings[ch][scf_pkg::IDX_FLAGS];
    outdoor = flags[scf_pkg::FLG_OUTDOOR];
    if (st == scf_pkg::STATUS_ABSENT) begin
      if (!outdoor) kept_val[ch] = 0;
      r.nomod = 1'b1;
      return r;
    end
    rawv = (st == scf_pkg::STATUS_OK) ? rin : 16'sd0;
    r.rerr = (rawv < setw(ch, scf_pkg::IDX_RAWMIN)) || (rawv > setw(ch, scf_pkg::IDX_RAWMAX));
    // two-point calibration, quotient truncated toward zero
    num = (longint'(setw(ch, scf_pkg::IDX_V1)) - setw(ch, scf_pkg::IDX_V0)) *
          (longint'(rawv) - setw(ch, scf_pkg::IDX_U0));
    den = longint'(setw(ch, scf_pkg::IDX_U1)) - setw(ch, scf_pkg::IDX_U0);
    q64 = (den != 0) ? num / den : 0;
    q = q64[15:0];
    q = q + setw(ch, scf_pkg::IDX_V0);
    v = q;
    // value limits
    if (v < setw(ch, scf_pkg::IDX_VMIN)) begin
      if (flags[scf_pkg::FLG_CLAMP_LO]) v = setw(ch, scf_pkg::IDX_VMIN);
      else begin r.verr = 1'b1; v = 0; end
    end
    if (v > setw(ch, scf_pkg::IDX_VMAX)) begin
      if (flags[scf_pkg::FLG_CLAMP_HI]) v = setw(ch, scf_pkg::IDX_VMAX);
      else begin r.verr = 1'b1; v = 0; end
    end
    // averaging
    avg = flags[scf_pkg::FLG_AVG_LO +: 2];
    if (avg == scf_pkg::AVG_TWO || avg == scf_pkg::AVG_THREE) begin
      if (avg == scf_pkg::AVG_TWO) sec_smp[ch] = 0;
      if (!outdoor) begin
        x = sec_smp[ch];
        y = prev_smp[ch];
        n = 0;
        sec_smp[ch] = y;
        prev_smp[ch] = v;
        if (v != 0) n++;
        if (x != 0) n++;
        if (y != 0) n++;
        if (n != 0) v = (v + x + y) / n;
      end
    end else if (avg == scf_pkg::AVG_EXP) begin
      if (prev_smp[ch] == 0) prev_smp[ch] = v;
      p = prev_smp[ch];
      v = (p * (scf_pkg::SCALE - EXP_WEIGHT) + v * EXP_WEIGHT) / scf_pkg::SCALE;
      prev_smp[ch] = v[15:0];
      v = prev_smp[ch];
    end
    // jump filter, indoor only
    if (!outdoor) begin
      sv = kept_val[ch];
      tol = int'(settings[ch][scf_pkg::IDX_TOL]);
      if ((v < sv + tol && v > sv - tol) || hold_cnt[ch] > scf_pkg::HOLD_LIMIT || sv == 0)
        hold_cnt[ch] = 0;
      else begin
        v = sv;
        r.held = 1'b1;
        if (hold_cnt[ch] < scf_pkg::HOLD_MAX) hold_cnt[ch]++;
      end
    end
    kept_val[ch] = v[15:0];
    r.value = v[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cond_word_t e;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < 16; s++) settings[c][s] = '0;
        prev_smp[c] = 0; sec_smp[c] = 0; kept_val[c] = 0; hold_cnt[c] = 0;
      end
      expected_words.delete();
      fail_count = 0;
      pending_results = 0;
      samples_seen = 0;
      held_seen = 0;
    end else begin
      // result word
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) report_mismatch("unexpected word", 0, 0);
        else begin
          e = expected_words.pop_front();
          if (out_value !== e.value) report_mismatch("value", out_value, e.value);
          if (out_raw_range_error !== e.rerr)
            report_mismatch("raw_range_error", out_raw_range_error, e.rerr);
          if (out_value_range_error !== e.verr)
            report_mismatch("value_range_error", out_value_range_error, e.verr);
          if (out_no_module !== e.nomod) report_mismatch("no_module", out_no_module, e.nomod);
          if (out_held !== e.held) report_mismatch("held", out_held, e.held);
          if (e.held) held_seen++;
        end
      end
      // input word
      if (in_valid && !in_stall) begin
        if (in_mode == scf_pkg::MODE_SAMPLE) samples_seen++;
        expected_words.push_back(condition_sample(in_mode, in_channel, in_setting_index,
                                                  in_setting_value, in_raw,
                                                  in_module_status));
      end
      pending_results = expected_words.size();
    end
  end

endmodule

@@ test/sensor_calibrate_and_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_calibrate_and_filter_test
// Drives setting writes and samples into the sensor conditioning block with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module sensor_calibrate_and_filter_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_WORDS    = 460;

  // module status codes exercised beyond ok and absent
  localparam logic [1:0] STATUS_ERRORS   = 2'd1;
  localparam logic [1:0] STATUS_RESERVED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = 1'b0;
  logic [5:0]         in_channel = '0;
  logic [3:0]         in_setting_index = '0;
  logic signed [15:0] in_setting_value = '0;
  logic signed [15:0] in_raw = '0;
  logic [1:0]         in_module_status = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_value;
  logic               out_raw_range_error;
  logic               out_value_range_error;
  logic               out_no_module;
  logic               out_held;
  int                 fail_count, pending_results, samples_seen, held_seen;
  int                 send_idle_pct = 0, recv_idle_pct = 0;
  int                 quiet_cycles = 0;
  int                 words_sent = 0;

  always #5 clk = ~clk;

  sensor_calibrate_and_filter uut (.*);

  sensor_calibrate_and_filter_checker chk (.*);

  // receiver stalls
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // watchdog on idle handshakes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("sensor_calibrate_and_filter_test: errors");
      $finish;
    end
  end

  // valid stays up after a taken word only when the next word follows at once
  task automatic send_word(logic mode, logic [5:0] ch, logic [3:0] idx,
                           logic [15:0] sval, logic [15:0] raw, logic [1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_channel <= ch;
    in_setting_index <= idx;
    in_setting_value <= sval;
    in_raw <= raw;
    in_module_status <= st;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic set_word(logic [5:0] ch, logic [3:0] idx, logic [15:0] sval);
    send_word(scf_pkg::MODE_SET, ch, idx, sval, 16'($urandom), 2'($urandom));
  endtask

  task automatic sample(logic [5:0] ch, logic [15:0] raw, logic [1:0] st);
    send_word(scf_pkg::MODE_SAMPLE, ch, 4'($urandom), 16'($urandom), raw, st);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // random but mostly usable channel setup
  task automatic setup_channel(logic [5:0] ch);
    int lo, span;
    lo = $urandom_range(2000) - 1000;
    span = $urandom_range(4000) + 1;
    set_word(ch, scf_pkg::IDX_U0, 16'(lo));
    set_word(ch, scf_pkg::IDX_U1, ($urandom_range(15) == 0) ? 16'(lo) : 16'(lo + span));
    set_word(ch, scf_pkg::IDX_V0, 16'($urandom_range(1000)));
    set_word(ch, scf_pkg::IDX_V1,
             ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(5000)));
    set_word(ch, scf_pkg::IDX_RAWMIN, 16'(lo - 200));
    set_word(ch, scf_pkg::IDX_RAWMAX, 16'(lo + span + 200));
    set_word(ch, scf_pkg::IDX_VMIN, 16'($urandom_range(300)));
    set_word(ch, scf_pkg::IDX_VMAX, 16'(4000 + $urandom_range(2000)));
    set_word(ch, scf_pkg::IDX_FLAGS, 16'($urandom_range(31)));
    set_word(ch, scf_pkg::IDX_TOL,
             ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(800)));
  endtask

  initial begin
    logic [5:0] ch;
    logic [1:0] st;
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every averaging mode, special cases
    set_word(6'd0, scf_pkg::IDX_U0, 16'h8000);
    set_word(6'd0, scf_pkg::IDX_U1, 16'h7FFF);
    set_word(6'd0, scf_pkg::IDX_V0, 16'h8000);
    set_word(6'd0, scf_pkg::IDX_V1, 16'h7FFF);
    set_word(6'd0, scf_pkg::IDX_RAWMIN, 16'hFF00);
    set_word(6'd0, scf_pkg::IDX_RAWMAX, 16'h0100);
    set_word(6'd0, scf_pkg::IDX_VMAX, 16'h7FFF);
    set_word(6'd0, scf_pkg::IDX_VMIN, 16'h8000);
    set_word(6'd0, 4'd15, 16'hFFFF);          // index beyond the table, ignored
    sample(6'd0, 16'h8000, scf_pkg::STATUS_OK);
    sample(6'd0, 16'h7FFF, scf_pkg::STATUS_OK);
    sample(6'd0, 16'h1234, STATUS_ERRORS);    // too many errors: raw as zero
    sample(6'd0, 16'h1234, STATUS_RESERVED);
    sample(6'd0, 16'h0000, scf_pkg::STATUS_ABSENT);
    sample(6'd63, 16'h0055, scf_pkg::STATUS_OK);   // equal raw points: quotient zero
    set_word(6'd63, scf_pkg::IDX_VMIN, 16'd10);    // unclamped low violation
    sample(6'd63, 16'h0055, scf_pkg::STATUS_OK);
    set_word(6'd63, scf_pkg::IDX_FLAGS, 16'h001F); // clamps, exponential, outdoor
    set_word(6'd63, scf_pkg::IDX_TOL, 16'hFFFF);
    sample(6'd63, 16'hFFFF, scf_pkg::STATUS_OK);
    for (i = 0; i < 4; i++) begin
      set_word(6'd1, scf_pkg::IDX_FLAGS, 16'(i << scf_pkg::FLG_AVG_LO));
      sample(6'd1, 16'($urandom), scf_pkg::STATUS_OK);
    end
    drain();

    // random phases with varying idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
      for (i = 0; i < PHASE_WORDS; i++) begin
        ch = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
        if ($urandom_range(49) == 0) setup_channel(ch);
        else if ($urandom_range(19) == 0)
          set_word(ch, 4'($urandom), 16'($urandom));
        else begin
          st = ($urandom_range(9) == 0) ? 2'($urandom) : scf_pkg::STATUS_OK;
          if ($urandom_range(3) == 0) sample(ch, 16'($urandom), st);
          else sample(ch, 16'($urandom_range(6000) - 1500), st);
        end
        if (i == PHASE_WORDS / 2) drain();
      end
    end
    drain();

    $display("sent %0d words, %0d samples, %0d held by the jump filter",
             words_sent, samples_seen, held_seen);
    if (fail_count == 0) $display("sensor_calibrate_and_filter_test: clean");
    else $display("sensor_calibrate_and_filter_test: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/scf_pkg.sv
rtl/core/scf_mul.sv
rtl/core/scf_div.sv
rtl/core/sensor_calibrate_and_filter.sv
rtl/core/scf_port_checker.sv
test/sensor_calibrate_and_filter_checker.sv
test/sensor_calibrate_and_filter_test.sv
